// ===== hw/rtl/pmftl_pkg.sv =====
`timescale 1ns / 1ps
package pmftl_pkg;

    localparam int BANKS  = 2;
    localparam int BLOCKS = 8;
    localparam int PAGES  = 4;
    localparam int WORDS  = 4;

    localparam int LBA_W  = 8;
    localparam int DATA_W = 32;
    localparam int OFF_W  = $clog2(WORDS);
    localparam int BANK_W = $clog2(BANKS);
    localparam int BLK_W  = $clog2(BLOCKS);
    localparam int PG_W   = $clog2(PAGES);
    localparam int BPN_W  = BLK_W + PG_W;          // page number inside a bank
    localparam int PPN_W  = BANK_W + BPN_W;        // page number over all banks
    localparam int FA_W   = PPN_W + OFF_W;         // flash word address
    localparam int CNT_W  = $clog2(PAGES + 1);

    localparam int BANK_PAGES  = BLOCKS * PAGES;
    localparam int ALL_PAGES   = BANKS * BANK_PAGES;
    localparam int FLASH_DEPTH = ALL_PAGES * WORDS;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_VALID   = 2'd1,
        ST_INVALID = 2'd2
    } t_pstat;

    typedef enum logic [1:0] {
        FR_READ,
        FR_MOVE,
        FR_PROG
    } t_frsel;

    typedef enum logic [1:0] {
        WS_NONE,
        WS_MOVE,
        WS_PROG
    } t_wsel;

    typedef enum logic [1:0] {
        STW_NONE,
        STW_SRC_FREE,
        STW_SPARE_FREE,
        STW_OP_INVALID
    } t_stw;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_RD_MAP,
        S_RD_DATA,
        S_FIND_RD,
        S_FIND_CK,
        S_CNT_RD,
        S_CNT_CK,
        S_MV_INIT,
        S_MV_RD,
        S_MV_CK,
        S_MV_CP_RD,
        S_MV_CP_WR,
        S_MV_META,
        S_MV_FREE,
        S_SP_CLR,
        S_SP_SET,
        S_PG_START,
        S_PG_OLD,
        S_PG_INV,
        S_PG_RD,
        S_PG_WR,
        S_PG_META,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   load;
        logic   res_ones;
        logic   cap_rd;
        logic   idx_clr;
        logic   idx_inc;
        logic   idx_victim;
        logic   cnt_clr;
        logic   cnt_step;
        logic   fill_clr;
        logic   fill_inc;
        logic   word_clr;
        logic   word_inc;
        logic   cap_ppn;
        logic   cap_owner;
        logic   cap_op;
        logic   old_clr;
        logic   set_gc;
        logic   set_full;
        logic   set_prog;
        logic   mask_clr;
        logic   set_spare;
        t_frsel frsel;
        t_wsel  flash_we;
        t_wsel  meta_we;
        t_stw   st_we;
    } t_cmd;

    typedef struct packed {
        logic   func;
        logic   final_wr;
        logic   mapped;
        logic   idx_last;
        logic   idx_spare;
        logic   page_last;
        logic   word_last;
        logic   fill_full;
        logic   gc_done;
        t_pstat pstat;
    } t_stat;

endpackage

// ===== hw/rtl/pmftl_ram.sv =====
`timescale 1ns / 1ps
module pmftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/pmftl_dp.sv =====
`timescale 1ns / 1ps
module pmftl_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmftl_pkg::t_cmd               i_cmd,
    input  logic                          i_func,
    input  logic [pmftl_pkg::LBA_W-1:0]   i_lba,
    input  logic [pmftl_pkg::DATA_W-1:0]  i_write_data,
    input  logic                          i_last,
    output pmftl_pkg::t_stat              o_stat,
    output logic [pmftl_pkg::DATA_W-1:0]  o_read_data,
    output logic                          o_programmed,
    output logic                          o_gc_ran,
    output logic                          o_full_error
);

    localparam int OFF_W  = pmftl_pkg::OFF_W;
    localparam int BANK_W = pmftl_pkg::BANK_W;
    localparam int BLK_W  = pmftl_pkg::BLK_W;
    localparam int PG_W   = pmftl_pkg::PG_W;
    localparam int BPN_W  = pmftl_pkg::BPN_W;
    localparam int PPN_W  = pmftl_pkg::PPN_W;
    localparam int FA_W   = pmftl_pkg::FA_W;
    localparam int CNT_W  = pmftl_pkg::CNT_W;
    localparam int DATA_W = pmftl_pkg::DATA_W;
    localparam int NPG    = pmftl_pkg::ALL_PAGES;

    logic                 r_func;
    logic [OFF_W-1:0]     r_off;
    logic [BANK_W-1:0]    r_bank;
    logic [BPN_W-1:0]     r_lpn;
    logic                 r_last;
    logic [DATA_W-1:0]    r_pend_words [pmftl_pkg::WORDS];
    logic [pmftl_pkg::WORDS-1:0] r_pend_mask;
    logic [BPN_W-1:0]     r_idx;
    logic [OFF_W-1:0]     r_word;
    logic [CNT_W-1:0]     r_fill;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     r_best;
    logic                 r_best_ok;
    logic [BLK_W-1:0]     r_victim;
    logic [BLK_W-1:0]     r_spare [pmftl_pkg::BANKS];
    logic [NPG-1:0]       r_map_valid;
    logic [NPG-1:0]       r_st_valid;
    logic                 r_st_vbit;
    logic [BPN_W-1:0]     r_ppn;
    logic [BPN_W-1:0]     r_op;
    logic                 r_old_valid;
    logic [BPN_W-1:0]     r_owner;
    logic [DATA_W-1:0]    r_read_data;
    logic                 r_prog;
    logic                 r_gc;
    logic                 r_full;

    logic [PPN_W-1:0]     w_mi;
    logic [PPN_W-1:0]     w_src;
    logic [BLK_W-1:0]     w_spare;
    logic [PG_W-1:0]      w_fillp;
    logic [CNT_W-1:0]     w_cnt_n;
    pmftl_pkg::t_pstat    w_pstat;

    logic [1:0]           w_st_q;
    logic                 w_st_we;
    logic [PPN_W-1:0]     w_st_waddr;
    logic [1:0]           w_st_wdata;
    logic [BPN_W-1:0]     w_map_q;
    logic                 w_map_we;
    logic [PPN_W-1:0]     w_map_waddr;
    logic [BPN_W-1:0]     w_map_wdata;
    logic [BPN_W-1:0]     w_own_q;
    logic                 w_own_we;
    logic [PPN_W-1:0]     w_own_waddr;
    logic [BPN_W-1:0]     w_own_wdata;
    logic [DATA_W-1:0]    w_fl_q;
    logic                 w_fl_we;
    logic [FA_W-1:0]      w_fl_waddr;
    logic [DATA_W-1:0]    w_fl_wdata;
    logic [FA_W-1:0]      w_fl_raddr;
    logic [DATA_W-1:0]    w_merge;

    assign w_mi    = {r_bank, r_lpn};
    assign w_src   = {r_bank, r_idx};
    assign w_spare = r_spare[r_bank];
    assign w_fillp = r_fill[PG_W-1:0];
    assign w_pstat = r_st_vbit ? pmftl_pkg::t_pstat'(w_st_q) : pmftl_pkg::ST_FREE;
    assign w_cnt_n = r_cnt + CNT_W'(w_pstat == pmftl_pkg::ST_INVALID);
    assign w_merge = r_pend_mask[r_word] ? r_pend_words[r_word]
                   : (r_old_valid ? w_fl_q : {DATA_W{1'b1}});

    always_comb begin
        case (i_cmd.frsel)
            pmftl_pkg::FR_MOVE: w_fl_raddr = {r_bank, r_idx, r_word};
            pmftl_pkg::FR_PROG: w_fl_raddr = {r_bank, r_op, r_word};
            default:            w_fl_raddr = {r_bank, w_map_q, r_off};
        endcase
    end

    always_comb begin
        w_fl_we    = 1'b0;
        w_fl_waddr = {r_bank, r_ppn, r_word};
        w_fl_wdata = w_merge;
        case (i_cmd.flash_we)
            pmftl_pkg::WS_MOVE: begin
                w_fl_we    = 1'b1;
                w_fl_waddr = {r_bank, w_spare, w_fillp, r_word};
                w_fl_wdata = w_fl_q;
            end
            pmftl_pkg::WS_PROG: begin
                w_fl_we = 1'b1;
            end
            default: ;
        endcase
    end

    // page program and page move share the metadata update
    always_comb begin
        w_own_we    = 1'b0;
        w_own_waddr = {r_bank, r_ppn};
        w_own_wdata = r_lpn;
        w_map_we    = 1'b0;
        w_map_waddr = w_mi;
        w_map_wdata = r_ppn;
        w_st_we     = 1'b0;
        w_st_waddr  = {r_bank, r_ppn};
        w_st_wdata  = pmftl_pkg::ST_VALID;
        case (i_cmd.meta_we)
            pmftl_pkg::WS_MOVE: begin
                w_own_we    = 1'b1;
                w_own_waddr = {r_bank, w_spare, w_fillp};
                w_own_wdata = r_owner;
                w_map_we    = 1'b1;
                w_map_waddr = {r_bank, r_owner};
                w_map_wdata = {w_spare, w_fillp};
                w_st_we     = 1'b1;
                w_st_waddr  = {r_bank, w_spare, w_fillp};
            end
            pmftl_pkg::WS_PROG: begin
                w_own_we = 1'b1;
                w_map_we = 1'b1;
                w_st_we  = 1'b1;
            end
            default: begin
                case (i_cmd.st_we)
                    pmftl_pkg::STW_SRC_FREE: begin
                        w_st_we    = 1'b1;
                        w_st_waddr = w_src;
                        w_st_wdata = pmftl_pkg::ST_FREE;
                    end
                    pmftl_pkg::STW_SPARE_FREE: begin
                        w_st_we    = 1'b1;
                        w_st_waddr = {r_bank, w_spare, w_fillp};
                        w_st_wdata = pmftl_pkg::ST_FREE;
                    end
                    pmftl_pkg::STW_OP_INVALID: begin
                        w_st_we    = 1'b1;
                        w_st_waddr = {r_bank, r_op};
                        w_st_wdata = pmftl_pkg::ST_INVALID;
                    end
                    default: ;
                endcase
            end
        endcase
    end

    pmftl_ram #(.WIDTH(2), .DEPTH(NPG)) u_status (
        .i_clk  (i_clk),
        .i_we   (w_st_we),
        .i_waddr(w_st_waddr),
        .i_wdata(w_st_wdata),
        .i_raddr(w_src),
        .o_rdata(w_st_q)
    );

    pmftl_ram #(.WIDTH(BPN_W), .DEPTH(NPG)) u_map (
        .i_clk  (i_clk),
        .i_we   (w_map_we),
        .i_waddr(w_map_waddr),
        .i_wdata(w_map_wdata),
        .i_raddr(w_mi),
        .o_rdata(w_map_q)
    );

    pmftl_ram #(.WIDTH(BPN_W), .DEPTH(NPG)) u_owner (
        .i_clk  (i_clk),
        .i_we   (w_own_we),
        .i_waddr(w_own_waddr),
        .i_wdata(w_own_wdata),
        .i_raddr(w_src),
        .o_rdata(w_own_q)
    );

    pmftl_ram #(.WIDTH(DATA_W), .DEPTH(pmftl_pkg::FLASH_DEPTH)) u_flash (
        .i_clk  (i_clk),
        .i_we   (w_fl_we),
        .i_waddr(w_fl_waddr),
        .i_wdata(w_fl_wdata),
        .i_raddr(w_fl_raddr),
        .o_rdata(w_fl_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= '0;
            r_st_valid  <= '0;
            r_pend_mask <= '0;
            for (int b = 0; b < pmftl_pkg::BANKS; b++) begin
                r_spare[b] <= BLK_W'(pmftl_pkg::BLOCKS - 1);
            end
        end else begin
            if (w_map_we) begin
                r_map_valid[w_map_waddr] <= 1'b1;
            end
            if (w_st_we) begin
                r_st_valid[w_st_waddr] <= 1'b1;
            end
            if (i_cmd.load && i_func) begin
                r_pend_mask[i_lba[OFF_W-1:0]] <= 1'b1;
            end else if (i_cmd.mask_clr) begin
                r_pend_mask <= '0;
            end
            if (i_cmd.set_spare) begin
                r_spare[r_bank] <= r_victim;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        r_st_vbit <= r_st_valid[w_src];
        if (i_cmd.load) begin
            r_func      <= i_func;
            r_off       <= i_lba[OFF_W-1:0];
            r_bank      <= i_lba[OFF_W +: BANK_W];
            r_lpn       <= i_lba[OFF_W+BANK_W +: BPN_W];
            r_last      <= i_last;
            r_read_data <= '0;
            r_prog      <= 1'b0;
            r_gc        <= 1'b0;
            r_full      <= 1'b0;
            if (i_func) begin
                r_pend_words[i_lba[OFF_W-1:0]] <= i_write_data;
            end
        end
        if (i_cmd.res_ones) begin
            r_read_data <= '1;
        end
        if (i_cmd.cap_rd) begin
            r_read_data <= w_fl_q;
        end
        if (i_cmd.set_gc) begin
            r_gc <= 1'b1;
        end
        if (i_cmd.set_full) begin
            r_full <= 1'b1;
        end
        if (i_cmd.set_prog) begin
            r_prog <= 1'b1;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_victim) begin
            r_idx <= {r_victim, PG_W'(0)};
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + BPN_W'(1);
        end
        if (i_cmd.word_clr) begin
            r_word <= '0;
        end else if (i_cmd.word_inc) begin
            r_word <= r_word + OFF_W'(1);
        end
        if (i_cmd.fill_clr) begin
            r_fill <= '0;
        end else if (i_cmd.fill_inc) begin
            r_fill <= r_fill + CNT_W'(1);
        end
        if (i_cmd.cnt_clr) begin
            r_cnt     <= '0;
            r_best_ok <= 1'b0;
        end else if (i_cmd.cnt_step) begin
            if (r_idx[PG_W-1:0] == PG_W'(pmftl_pkg::PAGES - 1)) begin
                // strict compare keeps the lowest block on a tie
                if (!r_best_ok || (w_cnt_n > r_best)) begin
                    r_victim  <= r_idx[BPN_W-1 -: BLK_W];
                    r_best    <= w_cnt_n;
                    r_best_ok <= 1'b1;
                end
                r_cnt <= '0;
            end else begin
                r_cnt <= w_cnt_n;
            end
        end
        if (i_cmd.cap_ppn) begin
            r_ppn <= r_idx;
        end
        if (i_cmd.cap_owner) begin
            r_owner <= w_own_q;
        end
        if (i_cmd.cap_op) begin
            r_op        <= w_map_q;
            r_old_valid <= 1'b1;
        end else if (i_cmd.old_clr) begin
            r_old_valid <= 1'b0;
        end
    end

    assign o_stat.func      = r_func;
    assign o_stat.final_wr  = (r_off == OFF_W'(pmftl_pkg::WORDS - 1)) || r_last;
    assign o_stat.mapped    = r_map_valid[w_mi];
    assign o_stat.idx_last  = (r_idx == BPN_W'(pmftl_pkg::BANK_PAGES - 1));
    assign o_stat.idx_spare = (r_idx[BPN_W-1 -: BLK_W] == w_spare);
    assign o_stat.page_last = (r_idx[PG_W-1:0] == PG_W'(pmftl_pkg::PAGES - 1));
    assign o_stat.word_last = (r_word == OFF_W'(pmftl_pkg::WORDS - 1));
    assign o_stat.fill_full = (r_fill == CNT_W'(pmftl_pkg::PAGES));
    assign o_stat.gc_done   = r_gc;
    assign o_stat.pstat     = w_pstat;

    assign o_read_data  = r_read_data;
    assign o_programmed = r_prog;
    assign o_gc_ran     = r_gc;
    assign o_full_error = r_full;

endmodule

// ===== hw/rtl/pmftl_ctrl.sv =====
`timescale 1ns / 1ps
module pmftl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  pmftl_pkg::t_stat  i_stat,
    output pmftl_pkg::t_cmd   o_cmd,
    output logic              o_busy,
    output logic              o_valid
);

    pmftl_pkg::t_state r_state;
    pmftl_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmftl_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            pmftl_pkg::S_IDLE, pmftl_pkg::S_DONE: begin
                o_busy  = 1'b0;
                o_valid = (r_state == pmftl_pkg::S_DONE);
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = pmftl_pkg::S_DECODE;
                end else begin
                    n_state = pmftl_pkg::S_IDLE;
                end
            end
            pmftl_pkg::S_DECODE: begin
                if (!i_stat.func) begin
                    if (i_stat.mapped) begin
                        n_state = pmftl_pkg::S_RD_MAP;
                    end else begin
                        o_cmd.res_ones = 1'b1;
                        n_state        = pmftl_pkg::S_DONE;
                    end
                end else if (!i_stat.final_wr) begin
                    n_state = pmftl_pkg::S_DONE;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = pmftl_pkg::S_FIND_RD;
                end
            end
            pmftl_pkg::S_RD_MAP: begin
                o_cmd.frsel = pmftl_pkg::FR_READ;
                n_state     = pmftl_pkg::S_RD_DATA;
            end
            pmftl_pkg::S_RD_DATA: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = pmftl_pkg::S_DONE;
            end
            pmftl_pkg::S_FIND_RD: begin
                if (!i_stat.idx_spare) begin
                    n_state = pmftl_pkg::S_FIND_CK;
                end else if (!i_stat.idx_last) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_stat.gc_done) begin
                    o_cmd.set_full = 1'b1;
                    o_cmd.mask_clr = 1'b1;
                    n_state        = pmftl_pkg::S_DONE;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = pmftl_pkg::S_CNT_RD;
                end
            end
            pmftl_pkg::S_FIND_CK: begin
                if (i_stat.pstat == pmftl_pkg::ST_FREE) begin
                    o_cmd.cap_ppn = 1'b1;
                    n_state       = pmftl_pkg::S_PG_START;
                end else if (!i_stat.idx_last) begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = pmftl_pkg::S_FIND_RD;
                end else if (i_stat.gc_done) begin
                    o_cmd.set_full = 1'b1;
                    o_cmd.mask_clr = 1'b1;
                    n_state        = pmftl_pkg::S_DONE;
                end else begin
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state       = pmftl_pkg::S_CNT_RD;
                end
            end
            pmftl_pkg::S_CNT_RD: begin
                if (!i_stat.idx_spare) begin
                    n_state = pmftl_pkg::S_CNT_CK;
                end else if (i_stat.idx_last) begin
                    n_state = pmftl_pkg::S_MV_INIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            pmftl_pkg::S_CNT_CK: begin
                o_cmd.cnt_step = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = pmftl_pkg::S_MV_INIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = pmftl_pkg::S_CNT_RD;
                end
            end
            pmftl_pkg::S_MV_INIT: begin
                o_cmd.idx_victim = 1'b1;
                o_cmd.fill_clr   = 1'b1;
                o_cmd.set_gc     = 1'b1;
                n_state          = pmftl_pkg::S_MV_RD;
            end
            pmftl_pkg::S_MV_RD: begin
                o_cmd.word_clr = 1'b1;
                n_state        = pmftl_pkg::S_MV_CK;
            end
            pmftl_pkg::S_MV_CK: begin
                if (i_stat.pstat == pmftl_pkg::ST_VALID) begin
                    o_cmd.cap_owner = 1'b1;
                    n_state         = pmftl_pkg::S_MV_CP_RD;
                end else begin
                    n_state = pmftl_pkg::S_MV_FREE;
                end
            end
            pmftl_pkg::S_MV_CP_RD: begin
                o_cmd.frsel = pmftl_pkg::FR_MOVE;
                n_state     = pmftl_pkg::S_MV_CP_WR;
            end
            pmftl_pkg::S_MV_CP_WR: begin
                o_cmd.flash_we = pmftl_pkg::WS_MOVE;
                if (i_stat.word_last) begin
                    n_state = pmftl_pkg::S_MV_META;
                end else begin
                    o_cmd.word_inc = 1'b1;
                    n_state        = pmftl_pkg::S_MV_CP_RD;
                end
            end
            pmftl_pkg::S_MV_META: begin
                o_cmd.meta_we  = pmftl_pkg::WS_MOVE;
                o_cmd.fill_inc = 1'b1;
                n_state        = pmftl_pkg::S_MV_FREE;
            end
            pmftl_pkg::S_MV_FREE: begin
                o_cmd.st_we = pmftl_pkg::STW_SRC_FREE;
                if (i_stat.page_last) begin
                    n_state = pmftl_pkg::S_SP_CLR;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = pmftl_pkg::S_MV_RD;
                end
            end
            pmftl_pkg::S_SP_CLR: begin
                if (i_stat.fill_full) begin
                    n_state = pmftl_pkg::S_SP_SET;
                end else begin
                    o_cmd.st_we    = pmftl_pkg::STW_SPARE_FREE;
                    o_cmd.fill_inc = 1'b1;
                end
            end
            pmftl_pkg::S_SP_SET: begin
                o_cmd.set_spare = 1'b1;
                o_cmd.idx_clr   = 1'b1;
                n_state         = pmftl_pkg::S_FIND_RD;
            end
            pmftl_pkg::S_PG_START: begin
                o_cmd.word_clr = 1'b1;
                if (i_stat.mapped) begin
                    n_state = pmftl_pkg::S_PG_OLD;
                end else begin
                    o_cmd.old_clr = 1'b1;
                    n_state       = pmftl_pkg::S_PG_RD;
                end
            end
            pmftl_pkg::S_PG_OLD: begin
                o_cmd.cap_op = 1'b1;
                n_state      = pmftl_pkg::S_PG_INV;
            end
            pmftl_pkg::S_PG_INV: begin
                o_cmd.st_we = pmftl_pkg::STW_OP_INVALID;
                n_state     = pmftl_pkg::S_PG_RD;
            end
            pmftl_pkg::S_PG_RD: begin
                o_cmd.frsel = pmftl_pkg::FR_PROG;
                n_state     = pmftl_pkg::S_PG_WR;
            end
            pmftl_pkg::S_PG_WR: begin
                o_cmd.flash_we = pmftl_pkg::WS_PROG;
                if (i_stat.word_last) begin
                    n_state = pmftl_pkg::S_PG_META;
                end else begin
                    o_cmd.word_inc = 1'b1;
                    n_state        = pmftl_pkg::S_PG_RD;
                end
            end
            pmftl_pkg::S_PG_META: begin
                o_cmd.meta_we  = pmftl_pkg::WS_PROG;
                o_cmd.set_prog = 1'b1;
                o_cmd.mask_clr = 1'b1;
                n_state        = pmftl_pkg::S_DONE;
            end
            default: begin
                n_state = pmftl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/page_mapping_ftl_greedy_gc_unit.sv =====
`timescale 1ns / 1ps
// Page-mapped flash translation unit with greedy garbage collection. Raise start with
// the item while busy is low; exactly one result follows, shown for a single cycle
// with o_valid high, and it must be captured then because the unit cannot be stalled.
// A new item may be started in the cycle that shows the result. A read looks up the
// map and then reads the flash word; a buffered write only stores its word. A write
// that programs a page walks the page status memory one entry at a time to find a free
// page, then merges and programs the page one word at a time. When collection runs it
// adds one status pass to count invalid pages, a copy of each valid page from the
// victim and a second free-page search. The status and flash memories have registered
// reads and are each accessed once per step of the sequencer.
module page_mapping_ftl_greedy_gc_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_func,
    input  logic [pmftl_pkg::LBA_W-1:0]   i_lba,
    input  logic [pmftl_pkg::DATA_W-1:0]  i_write_data,
    input  logic                          i_last,
    output logic                          o_valid,
    output logic [pmftl_pkg::DATA_W-1:0]  o_read_data,
    output logic                          o_programmed,
    output logic                          o_gc_ran,
    output logic                          o_full_error
);

    pmftl_pkg::t_cmd  w_cmd;
    pmftl_pkg::t_stat w_stat;

    pmftl_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .o_busy (busy),
        .o_valid(o_valid)
    );

    pmftl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_func      (i_func),
        .i_lba       (i_lba),
        .i_write_data(i_write_data),
        .i_last      (i_last),
        .o_stat      (w_stat),
        .o_read_data (o_read_data),
        .o_programmed(o_programmed),
        .o_gc_ran    (o_gc_ran),
        .o_full_error(o_full_error)
    );

endmodule

// ===== hw/rtl/pmftl_chk.sv =====
`timescale 1ns / 1ps
module pmftl_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_func,
    input logic [pmftl_pkg::LBA_W-1:0]   i_lba,
    input logic [pmftl_pkg::DATA_W-1:0]  i_write_data,
    input logic                          i_last,
    input logic                          o_valid,
    input logic [pmftl_pkg::DATA_W-1:0]  o_read_data,
    input logic                          o_programmed,
    input logic                          o_gc_ran,
    input logic                          o_full_error
);

    // every transfer is answered by the unit going busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held past one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_full_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_full_error |-> o_gc_ran && !o_programmed)
        else $error("full error without collection or with a program");

    a_read_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_programmed |-> o_read_data == '0)
        else $error("program result carries read data");

endmodule

bind page_mapping_ftl_greedy_gc_unit pmftl_chk u_pmftl_chk (.*);
